[sv/flha_pkg.sv]
package flha_pkg;

  localparam int ADDR_W       = 12;
  localparam int SIZE_W       = 13;
  localparam int BYTES_W      = 16;
  localparam int HEAP_UNITS   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_SHIFT    = 4;
  localparam int STEP_W       = 15;
  localparam int WALK_LIMIT   = 4 * HEAP_UNITS + 16;

  // Request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIT_STRATEGY = 2'd0;
  localparam logic [1:0] CFG_GROW_MIN     = 2'd1;
  localparam logic [1:0] CFG_ARENA_LIMIT  = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OOM = 2'd1,
    STAT_IGN = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASTART,
    S_AFIRST,
    S_AEVAL,
    S_ASPLIT,
    S_GROW,
    S_ISTART,
    S_IEVAL,
    S_M1,
    S_M2,
    S_M3,
    S_BW1,
    S_BW2,
    S_BW3,
    S_DONE
  } state_t;

endpackage

[sv/free_list_heap_allocator.sv]
// Allocate: a walk over the free blocks from the rover to the result; a first fit split adds
// state ASPLIT, a best fit split states BW1 to BW3, and each arena growth an insert walk.
// Free: an insert walk, then the merges. One header is read per cycle (memory reads are registered).
// One request is in flight at a time; a finished result waits in the output register.
// Reset (synchronous, active low) writes the sentinel header at unit 0, sets rover 0,
// arena end 1 and the configuration defaults; there is no memory clearing pass.
module free_list_heap_allocator
  import flha_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [BYTES_W-1:0]  in_request_bytes,
  input  logic [ADDR_W-1:0]   in_block_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   out_result_address,
  output logic [1:0]          out_status,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  // Header memories
  logic [ADDR_W-1:0] link_mem [HEAP_UNITS];
  logic [SIZE_W-1:0] size_mem [HEAP_UNITS];

  state_t state_r, state_nxt;

  logic              fit_r;
  logic [ADDR_W-1:0] grow_min_r, limit_r;
  logic [ADDR_W-1:0] rover_r, rover_nxt;
  logic [SIZE_W-1:0] arena_end_r, arena_end_nxt;
  logic [STEP_W-1:0] ast_r, ast_nxt, ist_r, ist_nxt;
  logic              first_r, first_nxt;
  logic              grow_r, grow_nxt;
  logic              have_best_r, have_best_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [SIZE_W-1:0] need_r, need_nxt;
  logic [ADDR_W-1:0] prevp_r, prevp_nxt, p_r, p_nxt;
  logic [ADDR_W-1:0] best_r, best_nxt, prevbest_r, prevbest_nxt;
  logic [SIZE_W-1:0] best_size_r, best_size_nxt;
  logic [ADDR_W-1:0] best_link_r, best_link_nxt;
  logic [ADDR_W-1:0] bp_r, bp_nxt, nx_r, nx_nxt, q_r, q_nxt, blk_r, blk_nxt;
  logic [SIZE_W-1:0] psize_r, psize_nxt, bsz_r, bsz_nxt;
  logic [ADDR_W-1:0] res_hdr_r, res_hdr_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_status_r;
  logic              out_load;

  // Memory access
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] rd_link_r;
  logic [SIZE_W-1:0] rd_size_r;
  logic              lk_we, sz_we, lk_we_m, sz_we_m;
  logic [ADDR_W-1:0] lk_waddr, sz_waddr, lk_waddr_m, sz_waddr_m;
  logic [ADDR_W-1:0] lk_wdata, lk_wdata_m;
  logic [SIZE_W-1:0] sz_wdata, sz_wdata_m;

  // Datapath helpers
  logic [BYTES_W:0]   bytes_sum;
  logic [SIZE_W-1:0]  req_units;
  logic               a_fit, a_exact, a_better, hb_now;
  logic [SIZE_W-1:0]  a_rem;
  logic [SIZE_W-1:0]  grow_nu;
  logic [SIZE_W:0]    grow_end;
  logic               i_brk;
  logic [STEP_W-1:0]  ast_inc, ist_inc;
  logic               merge_n, merge_p;
  logic [ADDR_W-1:0]  rest;

  assign bytes_sum = {1'b0, in_request_bytes} + (BYTES_W+1)'(HEADER_BYTES - 1);
  assign req_units = SIZE_W'(bytes_sum >> HDR_SHIFT) + SIZE_W'(1);

  assign a_fit    = rd_size_r >= need_r;
  assign a_exact  = rd_size_r == need_r;
  assign a_better = !have_best_r || (best_size_r > rd_size_r);
  assign hb_now   = have_best_r | (a_fit & fit_r);
  assign a_rem    = rd_size_r - need_r;

  assign grow_nu  = (need_r > SIZE_W'(grow_min_r)) ? need_r : SIZE_W'(grow_min_r);
  assign grow_end = {1'b0, arena_end_r} + {1'b0, grow_nu};

  assign i_brk = ((bp_r > p_r) && (bp_r < rd_link_r)) ||
                 ((p_r >= rd_link_r) && ((bp_r > p_r) || (bp_r < rd_link_r)));

  assign ast_inc = ast_r + STEP_W'(1);
  assign ist_inc = ist_r + STEP_W'(1);

  assign merge_n = ({2'b00, bp_r} + {1'b0, bsz_r}) == {2'b00, nx_r};
  assign merge_p = ({2'b00, p_r} + {1'b0, psize_r}) == {2'b00, bp_r};
  assign rest    = best_r + need_r[ADDR_W-1:0];

  // Sentinel header written during reset
  assign lk_we_m    = !rst_n | lk_we;
  assign sz_we_m    = !rst_n | sz_we;
  assign lk_waddr_m = rst_n ? lk_waddr : '0;
  assign sz_waddr_m = rst_n ? sz_waddr : '0;
  assign lk_wdata_m = rst_n ? lk_wdata : '0;
  assign sz_wdata_m = rst_n ? sz_wdata : '0;

  always_ff @(posedge clk) begin
    if (lk_we_m) link_mem[lk_waddr_m] <= lk_wdata_m;
    rd_link_r <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (sz_we_m) size_mem[sz_waddr_m] <= sz_wdata_m;
    rd_size_r <= size_mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fit_r       <= 1'b0;
      grow_min_r  <= ADDR_W'(1024);
      limit_r     <= ADDR_W'(4095);
      rover_r     <= '0;
      arena_end_r <= SIZE_W'(1);
      ast_r       <= '0;
      ist_r       <= '0;
      first_r     <= 1'b0;
      grow_r      <= 1'b0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rover_r     <= rover_nxt;
      arena_end_r <= arena_end_nxt;
      ast_r       <= ast_nxt;
      ist_r       <= ist_nxt;
      first_r     <= first_nxt;
      grow_r      <= grow_nxt;
      have_best_r <= have_best_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIT_STRATEGY: fit_r      <= cfg_data[0];
          CFG_GROW_MIN:     grow_min_r <= cfg_data;
          CFG_ARENA_LIMIT:  limit_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Walk registers and result
  always_ff @(posedge clk) begin
    need_r       <= need_nxt;
    prevp_r      <= prevp_nxt;
    p_r          <= p_nxt;
    best_r       <= best_nxt;
    prevbest_r   <= prevbest_nxt;
    best_size_r  <= best_size_nxt;
    best_link_r  <= best_link_nxt;
    bp_r         <= bp_nxt;
    nx_r         <= nx_nxt;
    q_r          <= q_nxt;
    blk_r        <= blk_nxt;
    psize_r      <= psize_nxt;
    bsz_r        <= bsz_nxt;
    res_hdr_r    <= res_hdr_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_addr_r   <= (res_hdr_r == '0) ? '0 : res_hdr_r + ADDR_W'(1);
      out_status_r <= res_status_r;
    end
  end

  // Next state, memory commands and outputs
  always_comb begin
    state_nxt      = state_r;
    rover_nxt      = rover_r;
    arena_end_nxt  = arena_end_r;
    ast_nxt        = ast_r;
    ist_nxt        = ist_r;
    first_nxt      = first_r;
    grow_nxt       = grow_r;
    have_best_nxt  = have_best_r;
    need_nxt       = need_r;
    prevp_nxt      = prevp_r;
    p_nxt          = p_r;
    best_nxt       = best_r;
    prevbest_nxt   = prevbest_r;
    best_size_nxt  = best_size_r;
    best_link_nxt  = best_link_r;
    bp_nxt         = bp_r;
    nx_nxt         = nx_r;
    q_nxt          = q_r;
    blk_nxt        = blk_r;
    psize_nxt      = psize_r;
    bsz_nxt        = bsz_r;
    res_hdr_nxt    = res_hdr_r;
    res_status_nxt = res_status_r;
    rd_addr        = p_r;
    lk_we          = 1'b0;
    lk_waddr       = p_r;
    lk_wdata       = '0;
    sz_we          = 1'b0;
    sz_waddr       = p_r;
    sz_wdata       = '0;
    in_ready       = 1'b0;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r & ~out_ready;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_mode == MODE_ALLOC) begin
            if (in_request_bytes == '0) begin
              res_hdr_nxt    = '0;
              res_status_nxt = STAT_IGN;
              state_nxt      = S_DONE;
            end else begin
              need_nxt      = req_units;
              have_best_nxt = 1'b0;
              ast_nxt       = '0;
              first_nxt     = 1'b1;
              state_nxt     = S_ASTART;
            end
          end else if ((in_block_address < ADDR_W'(2)) ||
                       ({1'b0, in_block_address - ADDR_W'(1)} >= arena_end_r)) begin
            res_hdr_nxt    = '0;
            res_status_nxt = STAT_IGN;
            state_nxt      = S_DONE;
          end else begin
            bp_nxt    = in_block_address - ADDR_W'(1);
            grow_nxt  = 1'b0;
            state_nxt = S_ISTART;
          end
        end
      end

      // Read the rover header to find the first candidate
      S_ASTART: begin
        rd_addr   = rover_r;
        state_nxt = S_AFIRST;
      end

      S_AFIRST: begin
        prevp_nxt = rover_r;
        p_nxt     = rd_link_r;
        rd_addr   = rd_link_r;
        if (first_r) begin
          first_nxt = 1'b0;
          state_nxt = S_AEVAL;
        end else begin
          ast_nxt = ast_inc;
          if (ast_inc > STEP_W'(WALK_LIMIT)) begin
            res_hdr_nxt    = '0;
            res_status_nxt = STAT_OOM;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_AEVAL;
          end
        end
      end

      // Check one free block against the request
      S_AEVAL: begin
        if (a_fit && a_exact) begin
          lk_we    = 1'b1;
          lk_waddr = prevp_r;
          lk_wdata = rd_link_r;
          if (!fit_r || (p_r == rover_r)) rover_nxt = prevp_r;
          res_hdr_nxt    = p_r;
          res_status_nxt = (p_r == '0) ? STAT_OOM : STAT_OK;
          state_nxt      = S_DONE;
        end else if (a_fit && !fit_r) begin
          sz_we     = 1'b1;
          sz_waddr  = p_r;
          sz_wdata  = a_rem;
          q_nxt     = p_r + a_rem[ADDR_W-1:0];
          rover_nxt = prevp_r;
          state_nxt = S_ASPLIT;
        end else begin
          if (a_fit && a_better) begin
            have_best_nxt = 1'b1;
            best_nxt      = p_r;
            prevbest_nxt  = prevp_r;
            best_size_nxt = rd_size_r;
            best_link_nxt = rd_link_r;
          end
          if (p_r == rover_r) begin
            state_nxt = hb_now ? S_BW1 : S_GROW;
          end else begin
            prevp_nxt = p_r;
            p_nxt     = rd_link_r;
            rd_addr   = rd_link_r;
            ast_nxt   = ast_inc;
            if (ast_inc > STEP_W'(WALK_LIMIT)) begin
              res_hdr_nxt    = '0;
              res_status_nxt = STAT_OOM;
              state_nxt      = S_DONE;
            end
          end
        end
      end

      // Write the size of the carved tail block
      S_ASPLIT: begin
        sz_we          = 1'b1;
        sz_waddr       = q_r;
        sz_wdata       = need_r;
        res_hdr_nxt    = q_r;
        res_status_nxt = (q_r == '0) ? STAT_OOM : STAT_OK;
        state_nxt      = S_DONE;
      end

      // Extend the arena and hand the new block to the insert walk
      S_GROW: begin
        if (grow_end > ({2'b00, limit_r} + (SIZE_W+1)'(1))) begin
          res_hdr_nxt    = '0;
          res_status_nxt = STAT_OOM;
          state_nxt      = S_DONE;
        end else begin
          arena_end_nxt = grow_end[SIZE_W-1:0];
          sz_we         = 1'b1;
          sz_waddr      = arena_end_r[ADDR_W-1:0];
          sz_wdata      = grow_nu;
          bp_nxt        = arena_end_r[ADDR_W-1:0];
          grow_nxt      = 1'b1;
          state_nxt     = S_ISTART;
        end
      end

      S_ISTART: begin
        rd_addr   = rover_r;
        p_nxt     = rover_r;
        ist_nxt   = '0;
        state_nxt = S_IEVAL;
      end

      // Find the predecessor of the freed block
      S_IEVAL: begin
        if (i_brk) begin
          nx_nxt    = rd_link_r;
          psize_nxt = rd_size_r;
          rd_addr   = bp_r;
          state_nxt = S_M1;
        end else begin
          p_nxt   = rd_link_r;
          rd_addr = rd_link_r;
          ist_nxt = ist_inc;
          if (ist_inc > STEP_W'(WALK_LIMIT)) begin
            res_hdr_nxt    = '0;
            res_status_nxt = grow_r ? STAT_OOM : STAT_IGN;
            state_nxt      = S_DONE;
          end
        end
      end

      S_M1: begin
        bsz_nxt   = rd_size_r;
        rd_addr   = nx_r;
        state_nxt = S_M2;
      end

      // Merge with the following block
      S_M2: begin
        if (merge_n) begin
          bsz_nxt = bsz_r + rd_size_r;
          blk_nxt = rd_link_r;
        end else begin
          blk_nxt = nx_r;
        end
        lk_we     = 1'b1;
        lk_waddr  = bp_r;
        lk_wdata  = blk_nxt;
        sz_we     = 1'b1;
        sz_waddr  = bp_r;
        sz_wdata  = bsz_nxt;
        state_nxt = S_M3;
      end

      // Merge with the preceding block
      S_M3: begin
        lk_we    = 1'b1;
        lk_waddr = p_r;
        if (merge_p) begin
          sz_we    = 1'b1;
          sz_waddr = p_r;
          sz_wdata = psize_r + bsz_r;
          lk_wdata = blk_r;
        end else begin
          lk_wdata = bp_r;
        end
        rover_nxt = p_r;
        if (grow_r) begin
          first_nxt = 1'b0;
          state_nxt = S_ASTART;
        end else begin
          res_hdr_nxt    = '0;
          res_status_nxt = STAT_OK;
          state_nxt      = S_DONE;
        end
      end

      // Best fit: split the head off the chosen block
      S_BW1: begin
        sz_we     = 1'b1;
        sz_waddr  = rest;
        sz_wdata  = best_size_r - need_r;
        lk_we     = 1'b1;
        lk_waddr  = rest;
        lk_wdata  = best_link_r;
        state_nxt = S_BW2;
      end

      S_BW2: begin
        sz_we     = 1'b1;
        sz_waddr  = best_r;
        sz_wdata  = need_r;
        lk_we     = 1'b1;
        lk_waddr  = best_r;
        lk_wdata  = rest;
        state_nxt = S_BW3;
      end

      S_BW3: begin
        lk_we    = 1'b1;
        lk_waddr = prevbest_r;
        lk_wdata = rest;
        if (best_r == rover_r) rover_nxt = prevbest_r;
        res_hdr_nxt    = best_r;
        res_status_nxt = (best_r == '0) ? STAT_OOM : STAT_OK;
        state_nxt      = S_DONE;
      end

      // Hold the result until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

  // A result with an address always reports success
  a_addr_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_addr_r == '0))
    else $error("result address set on a failed request");

  // The arena never runs past the memory
  a_arena : assert property (@(posedge clk) disable iff (!rst_n)
    arena_end_r <= SIZE_W'(HEAP_UNITS))
    else $error("arena end beyond heap");

  // The rover moves only when a walk completes
  a_rover : assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(rover_r) |-> ($past(!rst_n) || $past(state_r) == S_AEVAL ||
                           $past(state_r) == S_M3 || $past(state_r) == S_BW3))
    else $error("rover changed outside a list update");

  // A finished request reaches the output once the slot is free
  a_load : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (!out_valid_r || out_ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not transferred to output register");

endmodule
